### rtl/btm_pkg.sv
`default_nettype none
package btm_pkg;

    localparam int OP_W   = 3;
    localparam int KEY_W  = 60;
    localparam int AMT_W  = 31;
    localparam int CNT_W  = 31;
    localparam int ST_W   = 3;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 96;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_ERASE      = 3'd1,
        OP_COUNT      = 3'd2,
        OP_KTH        = 3'd3,
        OP_COUNT_LESS = 3'd4,
        OP_MIN_XOR    = 3'd5,
        OP_MAX_XOR    = 3'd6,
        OP_NOP        = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_FEW   = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL  = 3'd3,
        ST_OVF   = 3'd4
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amt;
    } req_t;

    localparam logic [CNT_W:0] CNT_MAX = {1'b0, {CNT_W{1'b1}}};

endpackage
`default_nettype wire

### rtl/btm_ram.sv
`default_nettype none
module btm_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### rtl/btm_front.sv
`default_nettype none
module btm_front
    import btm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     req_valid,
    input  wire logic                req_ready,
    output req_t                     req
);

    req_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t       dec;
    logic       push, pop;

    // classify the request
    always_comb begin
        dec.op  = op_t'(s_tdata[OP_W-1:0]);
        dec.key = s_tdata[OP_W +: KEY_W];
        dec.amt = s_tdata[OP_W+KEY_W +: AMT_W];
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = req_valid && req_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule
`default_nettype wire

### rtl/btm_engine.sv
`default_nettype none
module btm_engine
    import btm_pkg::*;
#(
    parameter int KEY_BITS   = 60,
    parameter int NODE_COUNT = 65536
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire req_t             req,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [KEY_W-1:0]      out_answer,
    output logic [ST_W-1:0]       out_status,
    output logic [CNT_W-1:0]      out_total
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int NODE_W = 2 * IDX_W + CNT_W;
    localparam int REM_W  = $clog2(KEY_BITS + 1);
    localparam logic [IDX_W+1:0] NODE_LIM = (IDX_W+2)'(NODE_COUNT);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_STEP  = 6'b000010,
        S_RD    = 6'b000100,
        S_LATCH = 6'b001000,
        S_NEW   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    function automatic logic [IDX_W-1:0] link_of(input logic [NODE_W-1:0] n, input logic b);
        return b ? n[2*IDX_W-1:IDX_W] : n[IDX_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cnt_of(input logic [NODE_W-1:0] n);
        return n[NODE_W-1 -: CNT_W];
    endfunction

    function automatic logic [NODE_W-1:0] with_cnt(input logic [NODE_W-1:0] n,
                                                  input logic [CNT_W-1:0] c);
        logic [NODE_W-1:0] r;
        r = n;
        r[NODE_W-1 -: CNT_W] = c;
        return r;
    endfunction

    function automatic logic [NODE_W-1:0] with_link(input logic [NODE_W-1:0] n, input logic b,
                                                   input logic [IDX_W-1:0] c);
        logic [NODE_W-1:0] r;
        r = n;
        if (b) begin
            r[2*IDX_W-1:IDX_W] = c;
        end else begin
            r[IDX_W-1:0] = c;
        end
        return r;
    endfunction

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [AMT_W-1:0]    amt_reg, amt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    cur_idx_reg, cur_idx_next;
    logic [NODE_W-1:0]   cur_node_reg, cur_node_next;
    logic [IDX_W-1:0]    rd_addr_reg, rd_addr_next;
    logic [KEY_W-1:0]    ans_reg, ans_next;
    status_t             st_reg, st_next;
    logic                phase_reg, phase_next;
    logic                probe_reg, probe_next;
    logic                sub_reg, sub_next;
    logic [CNT_W-1:0]    pend_reg, pend_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [NODE_W-1:0]   root_reg, root_next;
    logic [IDX_W:0]      next_free_reg, next_free_next;
    logic                out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]    out_answer_reg, out_answer_next;
    logic [ST_W-1:0]     out_status_reg, out_status_next;
    logic [CNT_W-1:0]    out_total_reg, out_total_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [NODE_W-1:0]   wr_data;
    logic [NODE_W-1:0]   rd_data;

    logic [REM_W-1:0]    bidx;
    logic                f, fx, is_max;
    logic [IDX_W-1:0]    c, c0, c1, xo;
    logic [CNT_W-1:0]    total, have, lc;
    logic [REM_W-1:0]    miss;
    logic [CNT_W:0]      ins_sum;
    logic [IDX_W+1:0]    need;
    logic [NODE_W-1:0]   m, m2;
    logic [CNT_W-1:0]    diff;

    btm_ram #(
        .WIDTH(NODE_W),
        .DEPTH(NODE_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    assign out_valid  = out_valid_reg;
    assign out_answer = out_answer_reg;
    assign out_status = out_status_reg;
    assign out_total  = out_total_reg;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        amt_next        = amt_reg;
        rem_next        = rem_reg;
        cur_idx_next    = cur_idx_reg;
        cur_node_next   = cur_node_reg;
        rd_addr_next    = rd_addr_reg;
        ans_next        = ans_reg;
        st_next         = st_reg;
        phase_next      = phase_reg;
        probe_next      = probe_reg;
        sub_next        = sub_reg;
        pend_next       = pend_reg;
        k_next          = k_reg;
        root_next       = root_reg;
        next_free_next  = next_free_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_answer_next = out_answer_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;
        req_ready       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = cur_idx_reg;
        wr_data         = cur_node_reg;

        bidx    = REM_W'(rem_reg - 1'b1);
        f       = key_reg[bidx];
        is_max  = (op_reg == OP_MAX_XOR);
        fx      = f ^ is_max;
        c       = link_of(cur_node_reg, f);
        c0      = link_of(cur_node_reg, 1'b0);
        c1      = link_of(cur_node_reg, 1'b1);
        xo      = link_of(cur_node_reg, ~fx);
        total   = cnt_of(root_reg);
        have    = (rem_reg == '0) ? cnt_of(cur_node_reg) : '0;
        miss    = (rem_reg == '0) ? '0 : rem_reg;
        ins_sum = {1'b0, total} + {1'b0, amt_reg};
        need    = {1'b0, next_free_reg} + (IDX_W+2)'(miss);
        m       = rd_data;
        lc      = cnt_of(rd_data);
        diff    = pend_reg - cnt_of(rd_data);
        m2      = (op_reg == OP_INSERT) ? with_cnt(m, cnt_of(m) + amt_reg)
                                        : with_cnt(m, cnt_of(m) - amt_reg);

        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    op_next       = req.op;
                    key_next      = req.key;
                    amt_next      = req.amt;
                    k_next        = req.amt;
                    cur_idx_next  = '0;
                    cur_node_next = root_reg;
                    rem_next      = REM_W'(KEY_BITS);
                    ans_next      = '0;
                    st_next       = ST_OK;
                    phase_next    = 1'b0;
                    probe_next    = 1'b0;
                    sub_next      = 1'b0;
                    state_next    = S_STEP;
                    case (req.op)
                        OP_KTH: begin
                            if (req.amt >= total) begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                        end
                        OP_MIN_XOR, OP_MAX_XOR: begin
                            if (total == '0) begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                        end
                        OP_NOP: begin
                            state_next = S_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_STEP: begin
                case (op_reg)
                    OP_INSERT: begin
                        if (!phase_reg) begin
                            if (rem_reg == '0 || c == '0) begin
                                if (ins_sum > CNT_MAX) begin
                                    st_next    = ST_OVF;
                                    state_next = S_DONE;
                                end else if (need > NODE_LIM) begin
                                    st_next    = ST_FULL;
                                    state_next = S_DONE;
                                end else begin
                                    root_next     = with_cnt(root_reg, ins_sum[CNT_W-1:0]);
                                    cur_node_next = with_cnt(root_reg, ins_sum[CNT_W-1:0]);
                                    cur_idx_next  = '0;
                                    rem_next      = REM_W'(KEY_BITS);
                                    phase_next    = 1'b1;
                                end
                            end else begin
                                rd_addr_next = c;
                                cur_idx_next = c;
                                rem_next     = REM_W'(rem_reg - 1'b1);
                                state_next   = S_RD;
                            end
                        end else if (rem_reg == '0) begin
                            state_next = S_DONE;
                        end else if (c != '0) begin
                            rd_addr_next = c;
                            cur_idx_next = c;
                            rem_next     = REM_W'(rem_reg - 1'b1);
                            state_next   = S_RD;
                        end else begin
                            if (cur_idx_reg == '0) begin
                                root_next = with_link(cur_node_reg, f, next_free_reg[IDX_W-1:0]);
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = with_link(cur_node_reg, f, next_free_reg[IDX_W-1:0]);
                            end
                            cur_idx_next   = next_free_reg[IDX_W-1:0];
                            next_free_next = next_free_reg + 1'b1;
                            state_next     = S_NEW;
                        end
                    end

                    OP_ERASE, OP_COUNT: begin
                        if (!phase_reg) begin
                            if (rem_reg == '0 || c == '0) begin
                                if (op_reg == OP_COUNT) begin
                                    ans_next   = KEY_W'(have);
                                    state_next = S_DONE;
                                end else if (have < amt_reg) begin
                                    st_next    = ST_FEW;
                                    state_next = S_DONE;
                                end else if (amt_reg == '0) begin
                                    state_next = S_DONE;
                                end else begin
                                    root_next     = with_cnt(root_reg, total - amt_reg);
                                    cur_node_next = with_cnt(root_reg, total - amt_reg);
                                    cur_idx_next  = '0;
                                    rem_next      = REM_W'(KEY_BITS);
                                    phase_next    = 1'b1;
                                end
                            end else begin
                                rd_addr_next = c;
                                cur_idx_next = c;
                                rem_next     = REM_W'(rem_reg - 1'b1);
                                state_next   = S_RD;
                            end
                        end else if (rem_reg == '0) begin
                            state_next = S_DONE;
                        end else begin
                            rd_addr_next = c;
                            cur_idx_next = c;
                            rem_next     = REM_W'(rem_reg - 1'b1);
                            state_next   = S_RD;
                        end
                    end

                    OP_KTH: begin
                        if (rem_reg == '0) begin
                            state_next = S_DONE;
                        end else if (c0 != '0) begin
                            rd_addr_next = c0;
                            probe_next   = 1'b1;
                            state_next   = S_RD;
                        end else begin
                            ans_next[bidx] = 1'b1;
                            if (c1 == '0) begin
                                state_next = S_DONE;
                            end else begin
                                rd_addr_next = c1;
                                cur_idx_next = c1;
                                rem_next     = REM_W'(rem_reg - 1'b1);
                                state_next   = S_RD;
                            end
                        end
                    end

                    OP_COUNT_LESS: begin
                        if (rem_reg == '0) begin
                            state_next = S_DONE;
                        end else if (c == '0) begin
                            if (f) begin
                                ans_next = ans_reg + KEY_W'(cnt_of(cur_node_reg));
                            end
                            state_next = S_DONE;
                        end else begin
                            // left count is parent count less the right child count
                            sub_next     = f;
                            pend_next    = cnt_of(cur_node_reg);
                            rd_addr_next = c;
                            cur_idx_next = c;
                            rem_next     = REM_W'(rem_reg - 1'b1);
                            state_next   = S_RD;
                        end
                    end

                    OP_MIN_XOR, OP_MAX_XOR: begin
                        if (rem_reg == '0) begin
                            state_next = S_DONE;
                        end else if (link_of(cur_node_reg, fx) != '0) begin
                            rd_addr_next = link_of(cur_node_reg, fx);
                            probe_next   = 1'b1;
                            state_next   = S_RD;
                        end else begin
                            if (!is_max) begin
                                ans_next[bidx] = 1'b1;
                            end
                            if (xo == '0) begin
                                state_next = S_DONE;
                            end else begin
                                rd_addr_next = xo;
                                cur_idx_next = xo;
                                rem_next     = REM_W'(rem_reg - 1'b1);
                                state_next   = S_RD;
                            end
                        end
                    end

                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_RD: begin
                state_next = S_LATCH;
            end

            S_LATCH: begin
                state_next = S_STEP;
                if (probe_reg) begin
                    probe_next = 1'b0;
                    if (op_reg == OP_KTH) begin
                        if (k_reg < lc) begin
                            cur_idx_next  = rd_addr_reg;
                            cur_node_next = m;
                            rem_next      = REM_W'(rem_reg - 1'b1);
                        end else begin
                            k_next         = k_reg - lc;
                            ans_next[bidx] = 1'b1;
                            if (c1 == '0) begin
                                state_next = S_DONE;
                            end else begin
                                rd_addr_next = c1;
                                cur_idx_next = c1;
                                rem_next     = REM_W'(rem_reg - 1'b1);
                                state_next   = S_RD;
                            end
                        end
                    end else begin
                        if (lc != '0) begin
                            cur_idx_next  = rd_addr_reg;
                            cur_node_next = m;
                            rem_next      = REM_W'(rem_reg - 1'b1);
                            if (is_max) begin
                                ans_next[bidx] = 1'b1;
                            end
                        end else begin
                            if (!is_max) begin
                                ans_next[bidx] = 1'b1;
                            end
                            if (xo == '0) begin
                                state_next = S_DONE;
                            end else begin
                                rd_addr_next = xo;
                                cur_idx_next = xo;
                                rem_next     = REM_W'(rem_reg - 1'b1);
                                state_next   = S_RD;
                            end
                        end
                    end
                end else begin
                    cur_node_next = m;
                    if (phase_reg) begin
                        wr_en         = 1'b1;
                        wr_data       = m2;
                        cur_node_next = m2;
                    end
                    if (sub_reg) begin
                        ans_next = ans_reg + KEY_W'(diff);
                        sub_next = 1'b0;
                    end
                end
            end

            S_NEW: begin
                wr_en         = 1'b1;
                wr_data       = with_cnt('0, amt_reg);
                cur_node_next = with_cnt('0, amt_reg);
                rem_next      = REM_W'(rem_reg - 1'b1);
                state_next    = S_STEP;
            end

            S_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_answer_next = ans_reg;
                    out_status_next = st_reg;
                    out_total_next  = total;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            root_reg      <= '0;
            next_free_reg <= (IDX_W+1)'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            root_reg      <= root_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        amt_reg        <= amt_next;
        rem_reg        <= rem_next;
        cur_idx_reg    <= cur_idx_next;
        cur_node_reg   <= cur_node_next;
        rd_addr_reg    <= rd_addr_next;
        ans_reg        <= ans_next;
        st_reg         <= st_next;
        phase_reg      <= phase_next;
        probe_reg      <= probe_next;
        sub_reg        <= sub_next;
        pend_reg       <= pend_next;
        k_reg          <= k_next;
        out_answer_reg <= out_answer_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
    end

endmodule
`default_nettype wire

### rtl/binary_trie_multiset_top.sv
// channel   dir   tdata fields (low bit up)                      tuser  tlast
// s_        in    opcode[2:0] key[62:3] amount[93:63] pad        -      -
// m_        out   answer[59:0] status[62:60] total[93:63] pad    -      -
//
// one request at a time on a single node memory port with registered read;
// a level read passes S_STEP, S_RD, S_LATCH; a kth or xor level whose
// first probe fails then reads its other child via S_RD, S_LATCH
// queries walk once; insert and erase walk twice (search, then update)
// reset: root cleared and next free node set to 1, no memory clearing pass
// a two-entry request queue and an output register let either side stall
`default_nettype none
module binary_trie_multiset_top
    import btm_pkg::*;
#(
    parameter int KEY_BITS   = 60,
    parameter int NODE_COUNT = 65536
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // opcode, key, amount
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata   // answer, status, total
);

    logic             req_valid, req_ready;
    req_t             req;
    logic [KEY_W-1:0] answer;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] total;

    btm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    btm_engine #(
        .KEY_BITS   (KEY_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_answer (answer),
        .out_status (status),
        .out_total  (total)
    );

    assign m_tdata = {{(M_DATA_W-KEY_W-ST_W-CNT_W){1'b0}}, total, status, answer};

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
module tb;
    import btm_pkg::*;

    localparam int NODES = 65536;
    localparam int LIMIT = 6000000;
    localparam logic [KEY_W-1:0] KMAX = {KEY_W{1'b1}};
    localparam logic [AMT_W-1:0] AMAX = {AMT_W{1'b1}};

    typedef struct {
        logic [KEY_W-1:0] answer;
        status_t          status;
        logic [CNT_W-1:0] total;
    } result_t;

    typedef struct {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amt;
        bit               typed;
        result_t          res;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    bit [63:0]        trie [NODES];
    int unsigned      alloc_ptr;
    result_t          pending_q[$];
    logic [KEY_W-1:0] key_pool[$];
    int               errors = 0;
    int unsigned      cycles = 0;
    int               rx_count = 0;

    binary_trie_multiset_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned link_at(int unsigned v, bit b);
        return b ? trie[v][31:16] : trie[v][15:0];
    endfunction

    function automatic longint unsigned count_at(int unsigned v);
        return trie[v][62:32];
    endfunction

    function automatic void set_count(int unsigned v, longint unsigned c);
        trie[v][62:32] = c[30:0];
    endfunction

    function automatic longint unsigned left_count(int unsigned v);
        int unsigned c;
        c = link_at(v, 1'b0);
        return c != 0 ? count_at(c) : 0;
    endfunction

    // trie update and answer for one request
    function automatic result_t trie_apply(op_t op, logic [KEY_W-1:0] key,
                                           logic [AMT_W-1:0] amt);
        result_t         r;
        longint unsigned tot, have, k, lc, amount;
        int unsigned     v, c, u, missing;
        bit              present, f;
        v = 0;
        present = 1;
        missing = 0;
        amount = amt;
        tot = count_at(0);
        r.answer = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                for (int i = KEY_W - 1; i >= 0; i--) begin
                    if (present) begin
                        c = link_at(v, key[i]);
                        if (c == 0) begin
                            present = 0;
                            missing++;
                        end else begin
                            v = c;
                        end
                    end else begin
                        missing++;
                    end
                end
                if (tot + amount > 64'h7FFF_FFFF) begin
                    r.status = ST_OVF;
                end else if (alloc_ptr + missing > NODES) begin
                    r.status = ST_FULL;
                end else begin
                    v = 0;
                    set_count(0, tot + amount);
                    for (int i = KEY_W - 1; i >= 0; i--) begin
                        c = link_at(v, key[i]);
                        if (c == 0) begin
                            c = alloc_ptr++;
                            trie[c] = '0;
                            if (key[i]) trie[v][31:16] = c[15:0];
                            else trie[v][15:0] = c[15:0];
                        end
                        v = c;
                        set_count(v, count_at(v) + amount);
                    end
                end
            end
            OP_ERASE, OP_COUNT: begin
                for (int i = KEY_W - 1; i >= 0 && present; i--) begin
                    c = link_at(v, key[i]);
                    if (c == 0) present = 0;
                    else v = c;
                end
                have = present ? count_at(v) : 0;
                if (op == OP_COUNT) begin
                    r.answer = KEY_W'(have);
                end else if (have < amount) begin
                    r.status = ST_FEW;
                end else if (amount > 0) begin
                    v = 0;
                    set_count(0, tot - amount);
                    for (int i = KEY_W - 1; i >= 0; i--) begin
                        v = link_at(v, key[i]);
                        set_count(v, count_at(v) - amount);
                    end
                end
            end
            OP_KTH: begin
                if (amount >= tot) begin
                    r.status = ST_RANGE;
                end else begin
                    k = amount;
                    for (int i = KEY_W - 1; i >= 0 && present; i--) begin
                        lc = left_count(v);
                        f = 0;
                        if (k >= lc) begin
                            k -= lc;
                            f = 1;
                            r.answer[i] = 1'b1;
                        end
                        v = link_at(v, f);
                        if (v == 0) present = 0;
                    end
                end
            end
            OP_COUNT_LESS: begin
                for (int i = KEY_W - 1; i >= 0 && present; i--) begin
                    if (key[i]) r.answer = r.answer + KEY_W'(left_count(v));
                    v = link_at(v, key[i]);
                    if (v == 0) present = 0;
                end
            end
            OP_MIN_XOR, OP_MAX_XOR: begin
                if (tot == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = KEY_W - 1; i >= 0 && present; i--) begin
                        f = key[i] ^ (op == OP_MAX_XOR);
                        u = link_at(v, f);
                        if (u != 0 && count_at(u) > 0) begin
                            v = u;
                            if (op == OP_MAX_XOR) r.answer[i] = 1'b1;
                        end else begin
                            if (op == OP_MIN_XOR) r.answer[i] = 1'b1;
                            v = link_at(v, !f);
                            if (v == 0) present = 0;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.total = CNT_W'(count_at(0));
        return r;
    endfunction

    // drive one request, predict on acceptance
    task automatic send(op_t op, logic [KEY_W-1:0] key, logic [AMT_W-1:0] amt,
                        bit typed, result_t want, int gap);
        result_t r;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, amt, key, op};
        do @(posedge aclk); while (!s_tready);
        r = trie_apply(op, key, amt);
        if (op == OP_INSERT && r.status == ST_OK && key_pool.size() < 64)
            key_pool.push_back(key);
        pending_q.push_back(typed ? want : r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int               sel;
        k = KEY_W'({$urandom, $urandom});
        sel = $urandom_range(0, 9);
        if (key_pool.size() != 0 && sel < 5) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if (sel == 4) k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        end else if (sel == 9) begin
            k = $urandom_range(0, 1) ? KMAX : '0;
        end
        return k;
    endfunction

    function automatic int draw_gap(int n);
        return (n % 300 < 40) ? 0 : $urandom_range(0, 10);
    endfunction

    // result side
    initial begin
        result_t r;
        int      stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = draw_gap(rx_count);
            if (rx_count == 150) stall = 800;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            rx_count++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t unexpected request result %h", $time, m_tdata);
            end else begin
                r = pending_q.pop_front();
                if (m_tdata[59:0] !== r.answer) begin
                    errors++;
                    $display("%0t answer exp %h act %h", $time, r.answer, m_tdata[59:0]);
                end
                if (m_tdata[62:60] !== r.status) begin
                    errors++;
                    $display("%0t status exp %0d act %0d", $time, r.status,
                             m_tdata[62:60]);
                end
                if (m_tdata[93:63] !== r.total) begin
                    errors++;
                    $display("%0t total exp %0d act %0d", $time, r.total, m_tdata[93:63]);
                end
            end
        end
    end

    initial begin
        row_t             rows[$];
        result_t          none;
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amt;
        longint unsigned  tot;
        int               sel;
        none = '{answer: '0, status: ST_OK, total: '0};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        alloc_ptr = 1;
        rows = '{
            '{OP_COUNT,      '0,   '0,  1, '{'0, ST_OK, 0}},
            '{OP_KTH,        '0,   '0,  1, '{'0, ST_RANGE, 0}},
            '{OP_MIN_XOR,    KMAX, '0,  1, '{'0, ST_RANGE, 0}},
            '{OP_MAX_XOR,    '0,   '0,  1, '{'0, ST_RANGE, 0}},
            '{OP_ERASE,      '0,   1,   1, '{'0, ST_FEW, 0}},
            '{OP_ERASE,      KMAX, '0,  1, '{'0, ST_OK, 0}},
            '{OP_INSERT,     KMAX, '0,  1, '{'0, ST_OK, 0}},
            '{OP_INSERT,     '0,   3,   1, '{'0, ST_OK, 3}},
            '{OP_INSERT,     KMAX, 2,   1, '{'0, ST_OK, 5}},
            '{OP_INSERT,     5,    AMAX, 1, '{'0, ST_OVF, 5}},
            '{OP_COUNT,      KMAX, '0,  1, '{2, ST_OK, 5}},
            '{OP_KTH,        '0,   '0,  1, '{'0, ST_OK, 5}},
            '{OP_KTH,        '0,   4,   1, '{KMAX, ST_OK, 5}},
            '{OP_KTH,        '0,   5,   1, '{'0, ST_RANGE, 5}},
            '{OP_COUNT_LESS, KMAX, '0,  1, '{3, ST_OK, 5}},
            '{OP_COUNT_LESS, '0,   '0,  1, '{'0, ST_OK, 5}},
            '{OP_MIN_XOR,    KMAX, '0,  1, '{'0, ST_OK, 5}},
            '{OP_MAX_XOR,    '0,   '0,  1, '{KMAX, ST_OK, 5}},
            '{OP_ERASE,      KMAX, 3,   1, '{'0, ST_FEW, 5}},
            '{OP_ERASE,      KMAX, 2,   1, '{'0, ST_OK, 3}},
            '{OP_MAX_XOR,    '0,   '0,  0, none},
            '{OP_NOP,        KMAX, AMAX, 1, '{'0, ST_OK, 3}},
            '{OP_INSERT,     60'h555_5555_5555_5555, 31'h7FFF_FFFC, 1,
              '{'0, ST_OK, 31'h7FFF_FFFF}},
            '{OP_INSERT,     1,    1,   1, '{'0, ST_OVF, 31'h7FFF_FFFF}},
            '{OP_ERASE,      60'h555_5555_5555_5555, 31'h7FFF_FFFC, 1, '{'0, ST_OK, 3}}
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            send(rows[i].op, rows[i].key, rows[i].amt, rows[i].typed, rows[i].res,
                 draw_gap(i + 100));
        drain();

        for (int n = 0; n < 1150; n++) begin
            if (n == 600) drain();
            sel = $urandom_range(0, 99);
            op = sel < 40 ? OP_INSERT : sel < 55 ? OP_ERASE : sel < 63 ? OP_COUNT :
                 sel < 73 ? OP_KTH : sel < 81 ? OP_COUNT_LESS : sel < 89 ? OP_MIN_XOR :
                 sel < 97 ? OP_MAX_XOR : OP_NOP;
            key = pick_key();
            tot = count_at(0);
            amt = AMT_W'($urandom_range(0, 12));
            if (op == OP_KTH)
                amt = AMT_W'($urandom_range(0, 9) == 0 ?
                              tot + $urandom_range(0, 2) :
                              (tot == 0 ? 0 : $urandom_range(0, 32'(tot - 1))));
            if ($urandom_range(0, 24) == 0) amt = AMT_W'($urandom);
            send(op, key, amt, 0, none, draw_gap(n));
        end
        drain();
        repeat (500) @(posedge aclk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### files.f
rtl/btm_pkg.sv
rtl/btm_ram.sv
rtl/btm_front.sv
rtl/btm_engine.sv
rtl/binary_trie_multiset_top.sv
tb/tb.sv
